### design/fixed_block_pool_allocator_core_assert.svh
// ----------------------------------------------------------------------------
// assertion macros for the block pool allocator
// ----------------------------------------------------------------------------
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_CORE_ASSERT_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_CORE_ASSERT_SVH

// condition must never hold
`define FBPA_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// same-cycle implication
`define FBPA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FBPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/fbpa_pkg.sv
// ----------------------------------------------------------------------------
// fbpa_pkg
// types, codes and helpers shared by the block pool allocator
// ----------------------------------------------------------------------------
`default_nettype none

package fbpa_pkg;

	localparam int NUM_POOLS    = 4;
	localparam int LINK_DEPTH   = 64;
	localparam int APB_ADDR_W   = 5;
	localparam int APB_DATA_W   = 32;

	localparam int POOL0_BLOCKS_DEF = 24;
	localparam int POOL1_BLOCKS_DEF = 16;
	localparam int POOL2_BLOCKS_DEF = 32;
	localparam int POOL3_BLOCKS_DEF = 64;
	localparam int MAX_BLOCKS_DEF   = 64;

	localparam logic [31:0] POOL0_BASE_RST = 32'h2001_C800;
	localparam logic [31:0] POOL1_BASE_RST = 32'h2001_E000;
	localparam logic [31:0] POOL2_BASE_RST = 32'h2001_E800;
	localparam logic [31:0] POOL3_BASE_RST = 32'h2001_F000;
	localparam logic [3:0]  POOL0_LOG2_RST = 4'd8;
	localparam logic [3:0]  POOL1_LOG2_RST = 4'd7;
	localparam logic [3:0]  POOL2_LOG2_RST = 4'd6;
	localparam logic [3:0]  POOL3_LOG2_RST = 4'd5;

	typedef enum logic [1:0] {
		MODE_ALLOC  = 2'd0,
		MODE_FREE   = 2'd1,
		MODE_REINIT = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_BAD_INDEX = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		REG_POOL0_BASE = 3'd0,
		REG_POOL1_BASE = 3'd1,
		REG_POOL2_BASE = 3'd2,
		REG_POOL3_BASE = 3'd3,
		REG_POOL0_LOG2 = 3'd4,
		REG_POOL1_LOG2 = 3'd5,
		REG_POOL2_LOG2 = 3'd6,
		REG_POOL3_LOG2 = 3'd7
	} reg_idx_t;

	typedef enum logic [2:0] {
		CMD_ALLOC,
		CMD_FREE,
		CMD_FREE_BAD,
		CMD_REINIT,
		CMD_NONE
	} cmd_kind_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_ALLOC,
		BK_REINIT
	} bk_state_t;

	typedef struct packed {
		mode_t       mode;
		logic [1:0]  pool;
		logic [5:0]  block_index;
	} in_item_t;

	typedef struct packed {
		status_t     status;
		logic [5:0]  granted_index;
		logic [31:0] granted_address;
	} res_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [1:0]  pool;
		logic [5:0]  idx;
	} cmd_t;

	// nn clear is the null link
	typedef struct packed {
		logic        nn;
		logic [5:0]  idx;
	} link_t;

	typedef struct packed {
		logic [NUM_POOLS-1:0][31:0] base;
		logic [NUM_POOLS-1:0][3:0]  size_log2;
	} cfg_t;

	localparam link_t LINK_NULL = '{nn: 1'b0, idx: 6'd0};

	function automatic logic [6:0] cap_of(input int blocks, input int max_blocks);
		int c;
		c = blocks;
		if (c > max_blocks) c = max_blocks;
		if (c > LINK_DEPTH) c = LINK_DEPTH;
		if (c < 1) c = 1;
		return c[6:0];
	endfunction

	// link of entry i in a freshly chained pool
	function automatic link_t chain_link(input logic [5:0] i, input logic [6:0] cap);
		logic [6:0] nxt;
		link_t      l;
		nxt = {1'b0, i} + 7'd1;
		if (nxt < cap) begin
			l = '{nn: 1'b1, idx: nxt[5:0]};
		end else begin
			l = LINK_NULL;
		end
		return l;
	endfunction

endpackage

`default_nettype wire

### design/fbpa_queue.sv
// ----------------------------------------------------------------------------
// fbpa_queue
// two-entry queue with push/full and pop/empty sides
// ----------------------------------------------------------------------------
`default_nettype none

module fbpa_queue #(
	parameter type T = logic
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire T     din,
	output logic      full,
	input  wire logic pop,
	output T          dout,
	output logic      empty
);

	T           slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop) rd_ptr_q <= !rd_ptr_q;
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= din;
	end

endmodule

`default_nettype wire

### design/fbpa_regs.sv
// ----------------------------------------------------------------------------
// fbpa_regs
// apb register file: pool base addresses and block size log2
// ----------------------------------------------------------------------------
`default_nettype none

module fbpa_regs
	import fbpa_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output logic                       pready,
	output cfg_t                       cfg
);

	cfg_t     cfg_q;
	reg_idx_t ridx;
	logic     wr_en;

	assign pready = 1'b1;
	assign ridx   = reg_idx_t'(paddr[4:2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base      <= {POOL3_BASE_RST, POOL2_BASE_RST, POOL1_BASE_RST, POOL0_BASE_RST};
			cfg_q.size_log2 <= {POOL3_LOG2_RST, POOL2_LOG2_RST, POOL1_LOG2_RST, POOL0_LOG2_RST};
		end else if (wr_en) begin
			unique case (ridx)
				REG_POOL0_BASE: cfg_q.base[0] <= pwdata;
				REG_POOL1_BASE: cfg_q.base[1] <= pwdata;
				REG_POOL2_BASE: cfg_q.base[2] <= pwdata;
				REG_POOL3_BASE: cfg_q.base[3] <= pwdata;
				REG_POOL0_LOG2: cfg_q.size_log2[0] <= pwdata[3:0];
				REG_POOL1_LOG2: cfg_q.size_log2[1] <= pwdata[3:0];
				REG_POOL2_LOG2: cfg_q.size_log2[2] <= pwdata[3:0];
				REG_POOL3_LOG2: cfg_q.size_log2[3] <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (ridx)
			REG_POOL0_BASE: prdata = cfg_q.base[0];
			REG_POOL1_BASE: prdata = cfg_q.base[1];
			REG_POOL2_BASE: prdata = cfg_q.base[2];
			REG_POOL3_BASE: prdata = cfg_q.base[3];
			REG_POOL0_LOG2: prdata = {28'd0, cfg_q.size_log2[0]};
			REG_POOL1_LOG2: prdata = {28'd0, cfg_q.size_log2[1]};
			REG_POOL2_LOG2: prdata = {28'd0, cfg_q.size_log2[2]};
			REG_POOL3_LOG2: prdata = {28'd0, cfg_q.size_log2[3]};
			default:        prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

### design/fbpa_front.sv
// ----------------------------------------------------------------------------
// fbpa_front
// accepts request transactions, classifies them and queues commands
// ----------------------------------------------------------------------------
`default_nettype none

module fbpa_front
	import fbpa_pkg::*;
#(
	parameter int POOL0_BLOCKS = POOL0_BLOCKS_DEF,
	parameter int POOL1_BLOCKS = POOL1_BLOCKS_DEF,
	parameter int POOL2_BLOCKS = POOL2_BLOCKS_DEF,
	parameter int POOL3_BLOCKS = POOL3_BLOCKS_DEF,
	parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire in_item_t item,
	output logic          full,
	output logic          cmd_valid,
	output cmd_t          cmd,
	input  wire logic     cmd_ready
);

	localparam logic [NUM_POOLS-1:0][6:0] CAP = {
		cap_of(POOL3_BLOCKS, MAX_BLOCKS), cap_of(POOL2_BLOCKS, MAX_BLOCKS),
		cap_of(POOL1_BLOCKS, MAX_BLOCKS), cap_of(POOL0_BLOCKS, MAX_BLOCKS)
	};

	cmd_t cls;
	logic cmd_empty;

	always_comb begin
		cls.pool = item.pool;
		cls.idx  = item.block_index;
		unique case (item.mode)
			MODE_ALLOC:  cls.kind = CMD_ALLOC;
			MODE_FREE: begin
				if ({1'b0, item.block_index} >= CAP[item.pool]) begin
					cls.kind = CMD_FREE_BAD;
				end else begin
					cls.kind = CMD_FREE;
				end
			end
			MODE_REINIT: cls.kind = CMD_REINIT;
			default:     cls.kind = CMD_NONE;
		endcase
	end

	fbpa_queue #(.T(cmd_t)) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (cls),
		.full   (full),
		.pop    (cmd_ready),
		.dout   (cmd),
		.empty  (cmd_empty)
	);

	assign cmd_valid = !cmd_empty;

endmodule

`default_nettype wire

### design/fbpa_back.sv
// ----------------------------------------------------------------------------
// fbpa_back
// executes commands on the free-list heads and link memory, queues results
// ----------------------------------------------------------------------------
`default_nettype none

module fbpa_back
	import fbpa_pkg::*;
#(
	parameter int POOL0_BLOCKS = POOL0_BLOCKS_DEF,
	parameter int POOL1_BLOCKS = POOL1_BLOCKS_DEF,
	parameter int POOL2_BLOCKS = POOL2_BLOCKS_DEF,
	parameter int POOL3_BLOCKS = POOL3_BLOCKS_DEF,
	parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cfg_t cfg,
	input  wire logic cmd_valid,
	input  wire cmd_t cmd,
	output logic      cmd_ready,
	output logic      empty,
	input  wire logic pop,
	output res_t      result
);

	`include "fixed_block_pool_allocator_core_assert.svh"

	localparam int MEM_DEPTH = NUM_POOLS * LINK_DEPTH;
	localparam int MEM_AW    = $clog2(MEM_DEPTH);

	localparam logic [NUM_POOLS-1:0][6:0] CAP = {
		cap_of(POOL3_BLOCKS, MAX_BLOCKS), cap_of(POOL2_BLOCKS, MAX_BLOCKS),
		cap_of(POOL1_BLOCKS, MAX_BLOCKS), cap_of(POOL0_BLOCKS, MAX_BLOCKS)
	};

	bk_state_t state_q, state_d;
	logic [1:0] pool_q;
	logic [5:0] idx_q;
	link_t      head_q [NUM_POOLS];

	link_t                link_mem [MEM_DEPTH];
	logic [MEM_DEPTH-1:0] lvld_q;
	link_t                link_rd_q;
	logic                 rdvld_q;

	logic              mem_we, mem_re;
	logic [MEM_AW-1:0] mem_wa, mem_ra;
	link_t             mem_wd;

	logic       head_we;
	logic [1:0] head_wp;
	link_t      head_wd;

	logic       res_push, res_full;
	res_t       res_d;
	link_t      head_sel, next_link;
	logic       reinit_last;

	assign head_sel    = head_q[cmd.pool];
	// an entry never written since reset still holds its reset chain
	assign next_link   = rdvld_q ? link_rd_q : chain_link(idx_q, CAP[pool_q]);
	assign reinit_last = ({1'b0, idx_q} == (CAP[pool_q] - 7'd1));

	always_comb begin
		state_d   = state_q;
		cmd_ready = 1'b0;
		res_push  = 1'b0;
		res_d     = '{status: ST_OK, granted_index: 6'd0, granted_address: 32'd0};
		mem_we    = 1'b0;
		mem_wa    = {cmd.pool, cmd.idx};
		mem_wd    = head_sel;
		mem_re    = 1'b0;
		mem_ra    = {cmd.pool, head_sel.idx};
		head_we   = 1'b0;
		head_wp   = cmd.pool;
		head_wd   = '{nn: 1'b1, idx: cmd.idx};
		unique case (state_q)
			BK_IDLE: begin
				// one free result slot guaranteed while idle
				if (cmd_valid && !res_full) begin
					cmd_ready = 1'b1;
					unique case (cmd.kind)
						CMD_ALLOC: begin
							if (head_sel.nn) begin
								mem_re  = 1'b1;
								state_d = BK_ALLOC;
							end else begin
								res_push     = 1'b1;
								res_d.status = ST_EMPTY;
							end
						end
						CMD_FREE: begin
							mem_we   = 1'b1;
							head_we  = 1'b1;
							res_push = 1'b1;
						end
						CMD_FREE_BAD: begin
							res_push     = 1'b1;
							res_d.status = ST_BAD_INDEX;
						end
						CMD_REINIT: begin
							head_we  = 1'b1;
							head_wd  = '{nn: 1'b1, idx: 6'd0};
							res_push = 1'b1;
							state_d  = BK_REINIT;
						end
						default: res_push = 1'b1;
					endcase
				end
			end
			BK_ALLOC: begin
				head_we               = 1'b1;
				head_wp               = pool_q;
				head_wd               = next_link;
				// the granted block leaves the list with a null link
				mem_we                = 1'b1;
				mem_wa                = {pool_q, idx_q};
				mem_wd                = LINK_NULL;
				res_push              = 1'b1;
				res_d.granted_index   = idx_q;
				res_d.granted_address = cfg.base[pool_q] +
					({26'd0, idx_q} << cfg.size_log2[pool_q]);
				state_d               = BK_IDLE;
			end
			BK_REINIT: begin
				mem_we = 1'b1;
				mem_wa = {pool_q, idx_q};
				mem_wd = chain_link(idx_q, CAP[pool_q]);
				if (reinit_last) state_d = BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			pool_q  <= 2'd0;
			idx_q   <= 6'd0;
			lvld_q  <= '0;
			for (int p = 0; p < NUM_POOLS; p++) begin
				head_q[p] <= '{nn: 1'b1, idx: 6'd0};
			end
		end else begin
			state_q <= state_d;
			if (cmd_ready) begin
				pool_q <= cmd.pool;
				idx_q  <= (cmd.kind == CMD_ALLOC) ? head_sel.idx : 6'd0;
			end else if (state_q == BK_REINIT) begin
				idx_q <= idx_q + 6'd1;
			end
			if (head_we) head_q[head_wp] <= head_wd;
			if (mem_we) lvld_q[mem_wa] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) link_mem[mem_wa] <= mem_wd;
		if (mem_re) begin
			link_rd_q <= link_mem[mem_ra];
			rdvld_q   <= lvld_q[mem_ra];
		end
	end

	fbpa_queue #(.T(res_t)) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (res_d),
		.full   (res_full),
		.pop    (pop),
		.dout   (result),
		.empty  (empty)
	);

	`FBPA_ASSERT_IMP(a_res_room, clk, arst_n, res_push, !res_full, "result pushed into full queue")
	`FBPA_ASSERT_NEXT(a_alloc_seq, clk, arst_n, mem_re, state_q == BK_ALLOC, "no alloc after read")
	`FBPA_ASSERT_IMP(a_reinit_bound, clk, arst_n, state_q == BK_REINIT, {1'b0, idx_q} < CAP[pool_q], "reinit overrun")
	`FBPA_ASSERT_NEVER(a_one_access, clk, arst_n, mem_we && mem_re, "link memory read and written together")

endmodule

`default_nettype wire

### design/fixed_block_pool_allocator_core.sv
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_core
// four lifo free-list pools of fixed-size blocks with alloc, free and reinit
// ----------------------------------------------------------------------------
// channel   direction  handshake          payload
// request   in         push / full        item   (mode, pool, block_index)
// response  out        empty / pop        result (status, granted_index,
//                                                 granted_address)
// config    in         apb psel/penable   pool bases and block size log2
//
// free, bad free and ignored requests finish in the idle state; allocate goes
// through a link memory read, then head update and address add
// reinit loads the head, then walks the chain writing one link per block of
// the pool through the single link memory write port
// reset restores the ascending chains at once through per-entry valid bits
// two-entry queues on each side let request and response stall independently
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_block_pool_allocator_core
	import fbpa_pkg::*;
#(
	parameter int POOL0_BLOCKS = POOL0_BLOCKS_DEF,
	parameter int POOL1_BLOCKS = POOL1_BLOCKS_DEF,
	parameter int POOL2_BLOCKS = POOL2_BLOCKS_DEF,
	parameter int POOL3_BLOCKS = POOL3_BLOCKS_DEF,
	parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	output logic                       full,
	input  wire in_item_t              item,
	output logic                       empty,
	input  wire logic                  pop,
	output res_t                       result,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output logic                       pready
);

	cfg_t cfg;
	logic cmd_valid;
	cmd_t cmd;
	logic cmd_ready;

	fbpa_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	fbpa_front #(
		.POOL0_BLOCKS (POOL0_BLOCKS),
		.POOL1_BLOCKS (POOL1_BLOCKS),
		.POOL2_BLOCKS (POOL2_BLOCKS),
		.POOL3_BLOCKS (POOL3_BLOCKS),
		.MAX_BLOCKS   (MAX_BLOCKS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.item      (item),
		.full      (full),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_ready (cmd_ready)
	);

	fbpa_back #(
		.POOL0_BLOCKS (POOL0_BLOCKS),
		.POOL1_BLOCKS (POOL1_BLOCKS),
		.POOL2_BLOCKS (POOL2_BLOCKS),
		.POOL3_BLOCKS (POOL3_BLOCKS),
		.MAX_BLOCKS   (MAX_BLOCKS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_ready (cmd_ready),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule

`default_nettype wire

### test/tb.sv
// ----------------------------------------------------------------------------
// tb
// checks the four-pool block allocator against a free-list predictor
// across directed requests, random traffic, register settings and
// random idling on both sides
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fbpa_pkg::*;

	localparam mode_t MODE_UNUSED = mode_t'(2'd3);
	// longest reinit walk plus both two-entry queues, with margin
	localparam int SETTLE_CYCLES = 100;
	localparam int unsigned POOL_CAP [NUM_POOLS] = '{
		POOL0_BLOCKS_DEF, POOL1_BLOCKS_DEF, POOL2_BLOCKS_DEF, POOL3_BLOCKS_DEF
	};

	logic                  clk;
	logic                  arst_n  = 1'b0;
	logic                  push    = 1'b0;
	in_item_t              item    = '0;
	logic                  pop     = 1'b0;
	logic                  psel    = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite  = 1'b0;
	logic [APB_ADDR_W-1:0] paddr   = '0;
	logic [APB_DATA_W-1:0] pwdata  = '0;
	logic                  full;
	logic                  empty;
	logic                  pready;
	res_t                  result;
	logic [APB_DATA_W-1:0] prdata;

	// free-list shadow: {valid, index}, valid clear is the null link
	logic [6:0]  next_link [NUM_POOLS][LINK_DEPTH];
	logic [6:0]  head_link [NUM_POOLS];
	logic [31:0] base_cfg  [NUM_POOLS];
	logic [3:0]  log2_cfg  [NUM_POOLS];

	res_t pending_results [$];
	int   held_blocks [NUM_POOLS][$];

	int send_idle_pct = 0;
	int pop_stall_pct = 0;
	int mismatches    = 0;
	int requests_sent = 0;
	int results_seen  = 0;
	int empty_allocs  = 0;
	int bad_frees     = 0;

	fixed_block_pool_allocator_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.item    (item),
		.empty   (empty),
		.pop     (pop),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic void rechain_pool(input int p);
		for (int i = 0; i < LINK_DEPTH; i++) begin
			next_link[p][i] = (i + 1 < POOL_CAP[p]) ? {1'b1, 6'(i + 1)} : 7'd0;
		end
		head_link[p] = {1'b1, 6'd0};
	endfunction

	// expected result of one request, updating the shadow free lists
	function automatic res_t pool_outcome(input in_item_t it);
		res_t       r;
		int         p;
		logic [5:0] h;
		r = '0;
		p = it.pool;
		case (it.mode)
			MODE_ALLOC: begin
				if (!head_link[p][6]) begin
					r.status = ST_EMPTY;
				end else begin
					h = head_link[p][5:0];
					head_link[p] = next_link[p][h];
					next_link[p][h] = 7'd0;
					r.granted_index = h;
					r.granted_address = base_cfg[p] + ({26'd0, h} << log2_cfg[p]);
				end
			end
			MODE_FREE: begin
				if (it.block_index >= POOL_CAP[p]) begin
					r.status = ST_BAD_INDEX;
				end else begin
					next_link[p][it.block_index] = head_link[p];
					head_link[p] = {1'b1, it.block_index};
				end
			end
			MODE_REINIT: begin
				rechain_pool(p);
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic in_item_t request(input mode_t m, input int p, input int idx);
		in_item_t it;
		it.mode = m;
		it.pool = 2'(p);
		it.block_index = 6'(idx);
		return it;
	endfunction

	task automatic send_item(input in_item_t it, output res_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= it;
		do @(posedge clk); while (full);
		want = pool_outcome(it);
		pending_results.push_back(want);
		requests_sent++;
	endtask

	task automatic wait_idle();
		push <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t r, input logic [31:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {r, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (r <= REG_POOL3_BASE) begin
			base_cfg[r[1:0]] = v;
		end else begin
			log2_cfg[r[1:0]] = v[3:0];
		end
		@(posedge clk);
	endtask

	task automatic write_setting(input logic [31:0] bases [NUM_POOLS],
			input logic [31:0] sizes [NUM_POOLS]);
		for (int p = 0; p < NUM_POOLS; p++) write_reg(reg_idx_t'(p), bases[p]);
		for (int p = 0; p < NUM_POOLS; p++) write_reg(reg_idx_t'(p + 4), sizes[p]);
	endtask

	// mostly hands back blocks that are out, with stray and repeated frees mixed in
	task automatic run_traffic(input int count, input int alloc_pct);
		in_item_t it;
		res_t     got;
		int       roll;
		int       p;
		int       k;
		repeat (count) begin
			roll = $urandom_range(99);
			p = $urandom_range(NUM_POOLS - 1);
			it = request(MODE_ALLOC, p, $urandom_range(63));
			if (roll >= alloc_pct && roll < 94) begin
				it.mode = MODE_FREE;
				if (held_blocks[p].size() != 0 && $urandom_range(9) < 8) begin
					k = $urandom_range(held_blocks[p].size() - 1);
					it.block_index = 6'(held_blocks[p][k]);
					held_blocks[p].delete(k);
				end
			end else if (roll >= 94 && roll < 98) begin
				it.mode = MODE_REINIT;
			end else if (roll >= 98) begin
				it.mode = MODE_UNUSED;
			end
			send_item(it, got);
			if (it.mode == MODE_ALLOC && got.status == ST_OK)
				held_blocks[p].push_back(got.granted_index);
			if (it.mode == MODE_REINIT) held_blocks[p].delete();
		end
	endtask

	task automatic test_directed_cases();
		res_t got;
		send_item(request(MODE_ALLOC, 0, 0), got);
		send_item(request(MODE_ALLOC, 3, 0), got);
		// frees just past capacity and at the top of the index range
		send_item(request(MODE_FREE, 0, POOL_CAP[0]), got);
		send_item(request(MODE_FREE, 1, 63), got);
		send_item(request(MODE_FREE, 2, POOL_CAP[2]), got);
		// block 63 is still on the list, so this is a double free
		send_item(request(MODE_FREE, 3, 63), got);
		send_item(request(MODE_ALLOC, 3, 0), got);
		send_item(request(MODE_UNUSED, 2, 63), got);
		send_item(request(MODE_REINIT, 3, 0), got);
		// run pool 1 dry, one allocation past empty
		repeat (POOL_CAP[1] + 1) send_item(request(MODE_ALLOC, 1, 0), got);
		send_item(request(MODE_REINIT, 1, 0), got);
	endtask

	task automatic test_reset_config_traffic();
		send_idle_pct = 0;
		pop_stall_pct = 0;
		run_traffic(180, 70);
	endtask

	task automatic test_extreme_config();
		wait_idle();
		write_setting('{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFF0},
			'{32'd2, 32'd12, 32'd15, 32'd0});
		send_idle_pct = 76;
		pop_stall_pct = 0;
		run_traffic(180, 45);
	endtask

	task automatic test_wrap_config();
		wait_idle();
		write_setting('{32'hFFFF_FF00, 32'h0000_0001, $urandom, 32'h7FFF_FFFF},
			'{32'd15, 32'd0, 32'd12, 32'd2});
		send_idle_pct = 0;
		pop_stall_pct = 76;
		run_traffic(180, 70);
	endtask

	task automatic test_random_config();
		wait_idle();
		// only the low nibble of a size register is meaningful
		write_setting('{$urandom, $urandom, $urandom, $urandom},
			'{$urandom, $urandom, $urandom, $urandom});
		send_idle_pct = 35;
		pop_stall_pct = 35;
		run_traffic(180, 50);
	endtask

	always @(posedge clk) begin
		res_t want;
		if (arst_n && pop && !empty) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transaction: status %0d index %0d address %h",
						result.status, result.granted_index, result.granted_address);
			end else begin
				want = pending_results.pop_front();
				results_seen++;
				if (want.status == ST_EMPTY) empty_allocs++;
				if (want.status == ST_BAD_INDEX) bad_frees++;
				if (result.status !== want.status ||
						result.granted_index !== want.granted_index ||
						result.granted_address !== want.granted_address) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch on transaction %0d: expected status %0d index %0d address %h",
							results_seen, want.status, want.granted_index,
							want.granted_address);
						$display("  got status %0d index %0d address %h",
							result.status, result.granted_index, result.granted_address);
					end
				end
			end
		end
		pop <= ($urandom_range(99) >= pop_stall_pct);
	end

	initial begin
		base_cfg = '{POOL0_BASE_RST, POOL1_BASE_RST, POOL2_BASE_RST, POOL3_BASE_RST};
		log2_cfg = '{POOL0_LOG2_RST, POOL1_LOG2_RST, POOL2_LOG2_RST, POOL3_LOG2_RST};
		for (int p = 0; p < NUM_POOLS; p++) rechain_pool(p);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_reset_config_traffic();
		test_extreme_config();
		test_wrap_config();
		test_random_config();
		wait_idle();

		$display("checked %0d results for %0d requests, %0d empty-pool allocations, %0d %s",
			results_seen, requests_sent, empty_allocs, bad_frees, "out-of-range frees");
		$display("four register settings and four idle patterns on request and response");
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire

### fixed_block_pool_allocator_core.f
+incdir+design
design/fbpa_pkg.sv
design/fbpa_queue.sv
design/fbpa_regs.sv
design/fbpa_front.sv
design/fbpa_back.sv
design/fixed_block_pool_allocator_core.sv
test/tb.sv
